// ----- hdl/pee_pkg.sv -----
// shared types and constants of the postfix expression evaluator
// no dependencies; imported by every module of the block except pee_ram
`timescale 1ns / 1ps

package pee_pkg;

	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	// character codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_UNDERFLOW = 3'd1,
		ERR_OVERFLOW  = 3'd2,
		ERR_DIVZERO   = 3'd3,
		ERR_EMPTY     = 3'd4
	} err_t;

	// one command from the front end: optional push, optional operator, optional end
	typedef struct packed {
		logic              push;
		logic [DATA_W-1:0] num;
		logic              op_en;
		op_t               op;
		logic              fin;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_OPRD,
		S_OPEX,
		S_DIV,
		S_END
	} state_t;

endpackage

// ----- hdl/pee_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/pee_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
// depends on pee_pkg for the data width
`timescale 1ns / 1ps

module pee_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pee_pkg::DATA_W-1:0] dividend,
	input  logic [pee_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [pee_pkg::DATA_W-1:0] quotient
);

	import pee_pkg::*;

	localparam int SW = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     step_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	// trial subtraction of one restoring step
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(DATA_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/pee_fifo.sv -----
// short command queue between front end and back end
// depends on pee_pkg for the command type and queue depth
`timescale 1ns / 1ps

module pee_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pee_pkg::cmd_t wdata,
	input  logic          rd,
	output pee_pkg::cmd_t rdata,
	output logic          full,
	output logic          empty
);

	import pee_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("write without count increment");

endmodule

// ----- hdl/pee_front.sv -----
// front end: accepts characters, builds decimal numbers, emits stack commands
// depends on pee_pkg for character codes and the command type
`timescale 1ns / 1ps

module pee_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_byte,
	input  logic          last_char,
	output logic          q_wr,
	output pee_pkg::cmd_t q_wdata,
	input  logic          q_full
);

	import pee_pkg::*;

	logic [DATA_W-1:0] acc_q;
	logic              open_q;
	logic              accept;
	logic              is_digit;
	logic              is_op;
	logic [DATA_W-1:0] acc_next;
	cmd_t              cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the character
	assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
	assign is_op    = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS) ||
	                  (char_byte == CHAR_STAR) || (char_byte == CHAR_SLASH);

	// acc * 10 + digit, wrapping
	assign acc_next = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0} +
	                  DATA_W'(char_byte - CHAR_ZERO);

	// build the command for this transaction
	always_comb begin
		cmd       = '0;
		cmd.fin   = last_char;
		if (is_digit) begin
			cmd.push = last_char;
			cmd.num  = acc_next;
		end else begin
			cmd.push  = open_q;
			cmd.num   = acc_q;
			cmd.op_en = is_op;
			case (char_byte)
				CHAR_PLUS:  cmd.op = OP_ADD;
				CHAR_MINUS: cmd.op = OP_SUB;
				CHAR_STAR:  cmd.op = OP_MUL;
				default:    cmd.op = OP_DIV;
			endcase
		end
	end

	assign q_wr    = accept && (cmd.push || cmd.op_en || cmd.fin);
	assign q_wdata = cmd;

	// digit run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			open_q <= 1'b0;
		end else if (accept) begin
			if (is_digit && !last_char) begin
				acc_q  <= acc_next;
				open_q <= 1'b1;
			end else begin
				acc_q  <= '0;
				open_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/pee_back.sv -----
// back end: stack sequencer with top-of-stack register, stack ram and divider
// depends on pee_pkg, pee_ram and pee_div
`timescale 1ns / 1ps

module pee_back #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pee_pkg::cmd_t              q_rdata,
	input  logic                       q_empty,
	output logic                       q_rd,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [pee_pkg::DATA_W-1:0] value,
	output logic [2:0]                 error_code
);

	import pee_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t            state_q;
	state_t            state_nxt;
	cmd_t              cmd_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] tos_q;
	err_t              err_q;
	logic              neg_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] value_q;
	err_t              code_q;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic              stack_full;
	logic              too_few;
	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] lhs;
	logic [DATA_W-1:0] op_res;
	logic [DATA_W-1:0] prod_lo;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] lhs_mag;
	logic [DATA_W-1:0] rhs_mag;
	logic              rhs_zero;

	assign cnt_m1     = cnt_q - CW'(1);
	assign cnt_m2     = cnt_q - CW'(2);
	assign stack_full = (cnt_q == CW'(STACK_DEPTH));
	assign too_few    = (cnt_q < CW'(2));
	assign out_free   = !out_valid_q || out_ready;
	assign rhs_zero   = (tos_q == '0);

	// stack below the top entry
	pee_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(tos_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(lhs)
	);

	// magnitudes for the divider
	assign lhs_mag = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
	assign rhs_mag = tos_q[DATA_W-1] ? (DATA_W'(0) - tos_q) : tos_q;

	pee_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(lhs_mag),
		.divisor (rhs_mag),
		.done    (div_done),
		.quotient(div_quo)
	);

	// add, subtract and low half of the product
	assign prod_lo = lhs * tos_q;
	always_comb begin
		case (cmd_q.op)
			OP_ADD:  op_res = lhs + tos_q;
			OP_SUB:  op_res = lhs - tos_q;
			OP_MUL:  op_res = prod_lo;
			default: op_res = '0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					if (q_rdata.push) begin
						state_nxt = S_PUSH;
					end else if (q_rdata.op_en) begin
						state_nxt = S_OPRD;
					end else begin
						state_nxt = S_END;
					end
				end
			end
			S_PUSH: begin
				if (cmd_q.op_en) begin
					state_nxt = S_OPRD;
				end else if (cmd_q.fin) begin
					state_nxt = S_END;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_OPRD: begin
				if (!too_few) begin
					state_nxt = S_OPEX;
				end else begin
					state_nxt = cmd_q.fin ? S_END : S_IDLE;
				end
			end
			S_OPEX: begin
				if (cmd_q.op == OP_DIV && !rhs_zero) begin
					state_nxt = S_DIV;
				end else begin
					state_nxt = cmd_q.fin ? S_END : S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_nxt = cmd_q.fin ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_rd      = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = cnt_m1[AW-1:0];
		ram_raddr = cnt_m2[AW-1:0];
		div_start = 1'b0;
		case (state_q)
			S_IDLE: q_rd = !q_empty;
			S_PUSH: ram_we = (cnt_q != '0) && !stack_full;
			S_OPRD: ram_re = !too_few;
			S_OPEX: div_start = (cmd_q.op == OP_DIV) && !rhs_zero;
			default: begin
				q_rd = 1'b0;
			end
		endcase
	end

	// stack state, errors and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new result may replace the one taken at this edge
			if (state_q == S_END && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_PUSH: begin
					if (stack_full) begin
						if (err_q == ERR_OK) begin
							err_q <= ERR_OVERFLOW;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OPRD: begin
					if (too_few && err_q == ERR_OK) begin
						err_q <= ERR_UNDERFLOW;
					end
				end
				S_OPEX: begin
					if (cmd_q.op != OP_DIV || rhs_zero) begin
						cnt_q <= cnt_m1;
					end
					if (cmd_q.op == OP_DIV && rhs_zero && err_q == ERR_OK) begin
						err_q <= ERR_DIVZERO;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cnt_q <= cnt_m1;
					end
				end
				S_END: begin
					if (out_free) begin
						cnt_q <= '0;
						err_q <= ERR_OK;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					cmd_q <= q_rdata;
				end
			end
			S_PUSH: begin
				if (!stack_full) begin
					tos_q <= cmd_q.num;
				end
			end
			S_OPEX: begin
				neg_q <= lhs[DATA_W-1] ^ tos_q[DATA_W-1];
				if (cmd_q.op != OP_DIV) begin
					tos_q <= op_res;
				end else if (rhs_zero) begin
					tos_q <= '0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					tos_q <= neg_q ? (DATA_W'(0) - div_quo) : div_quo;
				end
			end
			S_END: begin
				if (out_free) begin
					value_q <= (cnt_q != '0) ? tos_q : '0;
					if (err_q != ERR_OK) begin
						code_q <= err_q;
					end else if (cnt_q == '0) begin
						code_q <= ERR_EMPTY;
					end else begin
						code_q <= ERR_OK;
					end
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign error_code = code_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_opex_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OPEX) |-> ($past(state_q) == S_OPRD))
		else $error("operator executed without operand read");

	a_opex_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OPEX) |-> (cnt_q >= CW'(2)))
		else $error("operator executed with fewer than two entries");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside of divide wait");

endmodule

// ----- hdl/postfix_expression_evaluator_top.sv -----
// Postfix expression evaluator. The front end takes one character per cycle
// while its four-entry command queue has room; it turns digit runs into numbers
// and hands push, operator and end commands to the back end. The back end sets
// the sustained rate: it reads a command in its idle state and works through it
// before it reads the next. A push passes the push state; + - * pass the operand
// read (one stack ram read) and execute states; a number closed by an operator
// passes all three; / then waits on a 32-step shift-subtract divider; the end of
// an expression passes the end state plus any wait for the result to be taken.
// One transaction with the final-character flag yields one result: the top of
// stack and an error code. The stack ram needs no clearing pass after reset.
// depends on pee_pkg, pee_front, pee_fifo and pee_back
`timescale 1ns / 1ps

module postfix_expression_evaluator_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_byte,
	input  logic                              last_char,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pee_pkg::DATA_W-1:0] value,
	output logic [2:0]                        error_code
);

	import pee_pkg::*;

	cmd_t q_wdata;
	cmd_t q_rdata;
	logic q_wr;
	logic q_rd;
	logic q_full;
	logic q_empty;

	// character classification and number building
	pee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_byte(char_byte),
		.last_char(last_char),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	// command queue
	pee_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.rd    (q_rd),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	// stack execution and result
	pee_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.error_code(error_code)
	);

endmodule

// ----- verif/postfix_expression_evaluator_top_tb.sv -----
// self-checking testbench for postfix_expression_evaluator_top: streams postfix text
// through a queued driver, predicts each result in a behavioral stack evaluator
// depends on pee_pkg and postfix_expression_evaluator_top
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_tb;

	import pee_pkg::*;

	localparam int STACK_DEPTH  = 64;
	localparam int ITEM_TARGET  = 1900;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1_000_000;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} char_item_t;

	typedef struct packed {
		logic [31:0] value;
		err_t        code;
	} eval_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte  = 8'h00;
	logic        last_char  = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic signed [DATA_W-1:0] value;
	logic [2:0]  error_code;

	char_item_t   char_queue[$];
	eval_result_t pending_results[$];
	int           counted_items = 0;
	int           fail_count    = 0;
	int unsigned  cycle_count   = 0;
	int unsigned  send_gap      = 0;
	int unsigned  stall_left    = 0;
	logic         quiet         = 1'b0;

	// behavioral evaluator state
	logic [31:0] value_store [STACK_DEPTH];
	int unsigned depth_used  = 0;
	logic [31:0] digit_acc   = 32'd0;
	logic        digit_open  = 1'b0;
	err_t        first_err   = ERR_OK;

	postfix_expression_evaluator_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- evaluator

	function automatic logic is_digit(logic [7:0] c);
		return c >= CHAR_ZERO && c <= CHAR_NINE;
	endfunction

	function automatic logic is_operator(logic [7:0] c);
		return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH;
	endfunction

	task automatic note_fault(err_t e);
		if (first_err == ERR_OK)
			first_err = e;
	endtask

	task automatic push_stack(logic [31:0] v);
		if (depth_used >= STACK_DEPTH) begin
			note_fault(ERR_OVERFLOW);
		end else begin
			value_store[depth_used] = v;
			depth_used++;
		end
	endtask

	// signed quotient truncated toward zero, built on magnitudes
	function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? 32'd0 - a : a;
		mb = b[31] ? 32'd0 - b : b;
		q  = ma / mb;
		return (a[31] ^ b[31]) ? 32'd0 - q : q;
	endfunction

	task automatic apply_op(logic [7:0] c);
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] res;
		if (depth_used < 2) begin
			note_fault(ERR_UNDERFLOW);
			return;
		end
		rhs = value_store[depth_used-1];
		lhs = value_store[depth_used-2];
		depth_used -= 2;
		case (c)
			CHAR_PLUS:  res = lhs + rhs;
			CHAR_MINUS: res = lhs - rhs;
			CHAR_STAR:  res = lhs * rhs;
			default: begin
				if (rhs == 32'd0) begin
					note_fault(ERR_DIVZERO);
					res = 32'd0;
				end else begin
					res = div_toward_zero(lhs, rhs);
				end
			end
		endcase
		push_stack(res);
	endtask

	task automatic close_run();
		if (digit_open) begin
			push_stack(digit_acc);
			digit_acc  = 32'd0;
			digit_open = 1'b0;
		end
	endtask

	// one accepted character; queues the expected result on the final one
	task automatic eval_char(logic [7:0] c, logic fin);
		eval_result_t r;
		if (is_digit(c)) begin
			digit_acc  = digit_acc * 32'd10 + {24'd0, c - CHAR_ZERO};
			digit_open = 1'b1;
		end else begin
			close_run();
			if (is_operator(c))
				apply_op(c);
		end
		if (fin) begin
			close_run();
			r.value = (depth_used > 0) ? value_store[depth_used-1] : 32'd0;
			if (first_err != ERR_OK)
				r.code = first_err;
			else if (depth_used == 0)
				r.code = ERR_EMPTY;
			else
				r.code = ERR_OK;
			pending_results.push_back(r);
			depth_used = 0;
			digit_acc  = 32'd0;
			digit_open = 1'b0;
			first_err  = ERR_OK;
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_separator();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_digit(c) || is_operator(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_whitespace();
		case ($urandom_range(0, 7))
			0, 1, 2: return CHAR_SPACE;
			3:       return CHAR_TAB;
			4:       return CHAR_LF;
			5:       return CHAR_CR;
			default: return pick_separator();
		endcase
	endfunction

	task automatic put_char(logic [7:0] c, logic fin);
		char_item_t item;
		item.ch  = c;
		item.fin = fin;
		char_queue.push_back(item);
		counted_items++;
	endtask

	task automatic put_text(string s, logic fin);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], fin && (i == s.len() - 1));
	endtask

	task automatic put_seps();
		repeat ($urandom_range(1, 2))
			put_char(pick_whitespace(), 1'b0);
	endtask

	task automatic put_op();
		case ($urandom_range(0, 3))
			0:       put_char(CHAR_PLUS, 1'b0);
			1:       put_char(CHAR_MINUS, 1'b0);
			2:       put_char(CHAR_STAR, 1'b0);
			default: put_char(CHAR_SLASH, 1'b0);
		endcase
	endtask

	// small values, full-width values, extremes, leading zeros and wrapping runs
	task automatic put_number();
		int unsigned r;
		string s;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			s = "0";
		end else if (r < 45) begin
			s = $sformatf("%0d", $urandom_range(0, 99));
		end else if (r < 70) begin
			s = $sformatf("%0d", $urandom());
		end else if (r < 80) begin
			case ($urandom_range(0, 3))
				0:       s = "4294967295";
				1:       s = "2147483647";
				2:       s = "2147483648";
				default: s = "1";
			endcase
		end else if (r < 88) begin
			s = {"00", $sformatf("%0d", $urandom_range(0, 999))};
		end else begin
			s = "";
			repeat ($urandom_range(11, 16))
				s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		put_text(s, 1'b0);
	endtask

	// flag the end either on the last queued character or on a trailing separator
	task automatic close_expression();
		char_item_t item;
		if ($urandom_range(0, 2) == 0) begin
			put_char(pick_whitespace(), 1'b1);
		end else begin
			item     = char_queue.pop_back();
			item.fin = 1'b1;
			char_queue.push_back(item);
		end
	endtask

	task automatic put_wellformed();
		int unsigned operands;
		int unsigned pushed;
		int          depth;
		logic        prev_num;
		operands = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
		pushed   = 0;
		depth    = 0;
		prev_num = 1'b0;
		while (pushed < operands || depth > 1) begin
			if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 0)) begin
				if (prev_num || $urandom_range(0, 3) == 0)
					put_seps();
				put_number();
				depth++;
				pushed++;
				prev_num = 1'b1;
			end else begin
				if ($urandom_range(0, 2) == 0)
					put_seps();
				put_op();
				depth--;
				prev_num = 1'b0;
			end
		end
		close_expression();
	endtask

	// random token soup: underflow, leftover entries, stray bytes
	task automatic put_broken();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 3))
				0: begin
					put_char(pick_separator(), 1'b0);
					put_number();
				end
				1:       put_op();
				2:       put_char(pick_separator(), 1'b0);
				default: put_char(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		close_expression();
	endtask

	task automatic put_noise();
		repeat ($urandom_range(1, 6))
			put_char(8'($urandom_range(0, 255)), 1'b0);
		close_expression();
	endtask

	// push count numbers, which can fill the stack to or past its depth
	task automatic put_flood(int unsigned count);
		repeat (count) begin
			put_text($sformatf("%0d", $urandom_range(0, 999)), 1'b0);
			put_char(pick_whitespace(), 1'b0);
		end
		repeat ($urandom_range(0, 3))
			put_op();
		close_expression();
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin : driver
		char_item_t item;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			char_byte <= 8'h00;
			last_char <= 1'b0;
			send_gap  <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0 || char_queue.size() == 0) begin
				in_valid <= 1'b0;
				if (send_gap != 0)
					send_gap <= send_gap - 1;
			end else begin
				item = char_queue.pop_front();
				in_valid  <= 1'b1;
				char_byte <= item.ch;
				last_char <= item.fin;
				send_gap  <= pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(posedge clk or negedge arst_n) begin : receiver
		int unsigned g;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && out_ready) begin
			g = pick_gap();
			stall_left <= g;
			out_ready  <= (g == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			g = pick_gap();
			stall_left <= g;
			out_ready  <= (g == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_failure(string msg);
		fail_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// result transactions are checked before the same edge's input is predicted
	always @(posedge clk) begin : scoreboard
		eval_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_failure($sformatf("result with none pending: value %0d code %0d",
						value, error_code));
				end else begin
					want = pending_results.pop_front();
					if (value !== want.value)
						report_failure($sformatf("value: expected %0d got %0d",
							$signed(want.value), value));
					if (error_code !== want.code)
						report_failure($sformatf("error_code: expected %0d got %0d",
							want.code, error_code));
				end
			end
			if (in_valid && in_ready)
				eval_char(char_byte, last_char);
		end
	end

	// cycle limit and calm stretches without idling
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ($urandom_range(0, 399) == 0)
			quiet <= !quiet;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("postfix_expression_evaluator_top_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned r;

		// directed: most negative over minus one, subtract and divide
		put_text("2147483648 0 1-/", 1'b1);
		// operator on an empty stack
		put_text("+", 1'b1);
		// end with nothing pushed
		put_text(" ", 1'b1);
		// zero divisor, nul byte as separator
		put_text("7", 1'b0);
		put_char(8'h00, 1'b0);
		put_text("0/", 1'b1);
		// multiply and add, all-ones byte as separator
		put_text("9", 1'b0);
		put_char(8'hFF, 1'b0);
		put_text("9*1+", 1'b1);

		// random part, opened by a stack overflow
		put_flood(66);
		while (counted_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 74)
				put_wellformed();
			else if (r < 88)
				put_broken();
			else if (r < 98)
				put_noise();
			else
				put_flood($urandom_range(60, 70));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (char_queue.size() != 0 || in_valid);
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("postfix_expression_evaluator_top_tb passed");
		else
			$display("postfix_expression_evaluator_top_tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pee_pkg.sv
hdl/pee_ram.sv
hdl/pee_div.sv
hdl/pee_fifo.sv
hdl/pee_front.sv
hdl/pee_back.sv
hdl/postfix_expression_evaluator_top.sv
verif/postfix_expression_evaluator_top_tb.sv
